// ----- src/htfr_pkg.sv -----
// ----------------------------------------------------------------------------
// htfr_pkg: shared types and constants for the header/trailer frame receiver
// Register map, field widths, reset values and controller/datapath signals.
// ----------------------------------------------------------------------------
package htfr_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 6;
	localparam int IDX_W       = 5;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int REG_SEL_W   = 3;

	// register indexes (byte address = 4 * index)
	localparam logic [REG_SEL_W-1:0] REG_PAYLOAD_LENGTH     = 3'd0;
	localparam logic [REG_SEL_W-1:0] REG_HEADER_FIRST       = 3'd1;
	localparam logic [REG_SEL_W-1:0] REG_HEADER_SECOND      = 3'd2;
	localparam logic [REG_SEL_W-1:0] REG_USE_HEADER_SECOND  = 3'd3;
	localparam logic [REG_SEL_W-1:0] REG_TRAILER_FIRST      = 3'd4;
	localparam logic [REG_SEL_W-1:0] REG_TRAILER_SECOND     = 3'd5;
	localparam logic [REG_SEL_W-1:0] REG_USE_TRAILER_SECOND = 3'd6;

	// reset values
	localparam logic [LEN_W-1:0]  RST_PAYLOAD_LENGTH = 6'd16;
	localparam logic [BYTE_W-1:0] RST_HEADER_FIRST   = 8'd13;
	localparam logic [BYTE_W-1:0] RST_HEADER_SECOND  = 8'd10;
	localparam logic [BYTE_W-1:0] RST_TRAILER_FIRST  = 8'd10;
	localparam logic [BYTE_W-1:0] RST_TRAILER_SECOND = 8'd13;

	typedef struct packed {
		logic [LEN_W-1:0]  payload_length;
		logic [BYTE_W-1:0] header_first;
		logic [BYTE_W-1:0] header_second;
		logic              use_header_second;
		logic [BYTE_W-1:0] trailer_first;
		logic [BYTE_W-1:0] trailer_second;
		logic              use_trailer_second;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_fill;   // hunting byte taken: restart payload count
		logic store;      // payload byte taken: write and count it
		logic emit;       // frame complete: start reading the payload out
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hdr1_match;
		logic hdr2_match;
		logic trl1_match;
		logic trl2_match;
		logic fill_done;   // this payload byte ends the payload
		logic drain_busy;  // payload reads still to be issued
	} dp_status_t;

endpackage

// ----- src/htfr_ram.sv -----
// ----------------------------------------------------------------------------
// htfr_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module htfr_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 32,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/htfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// htfr_ctrl: frame receive state machine
// Tracks hunt / header / payload / trailer phases and the payload drain.
// ----------------------------------------------------------------------------
module htfr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  use_header_second,
	input  logic                  use_trailer_second,
	input  htfr_pkg::dp_status_t  status,
	output htfr_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [5:0] {
		ST_HUNT    = 6'b000001,
		ST_HDR2    = 6'b000010,
		ST_PAYLOAD = 6'b000100,
		ST_TRL1    = 6'b001000,
		ST_TRL2    = 6'b010000,
		ST_DRAIN   = 6'b100000
	} state_t;

	state_t state_q, state_nxt;
	logic   take;

	assign in_stall = (state_q == ST_DRAIN);
	assign take     = in_valid && !in_stall;

	always_comb begin
		state_nxt    = state_q;
		cmd.clr_fill = 1'b0;
		cmd.store    = 1'b0;
		cmd.emit     = 1'b0;
		unique case (state_q)
			ST_HUNT: begin
				if (take) begin
					cmd.clr_fill = 1'b1;
					if (status.hdr1_match) begin
						state_nxt = use_header_second ? ST_HDR2 : ST_PAYLOAD;
					end
				end
			end
			ST_HDR2: begin
				if (take) begin
					if (status.hdr2_match) begin
						state_nxt = ST_PAYLOAD;
					end else if (!status.hdr1_match) begin
						state_nxt = ST_HUNT;
					end
				end
			end
			ST_PAYLOAD: begin
				if (take) begin
					cmd.store = 1'b1;
					if (status.fill_done) begin
						state_nxt = ST_TRL1;
					end
				end
			end
			ST_TRL1: begin
				if (take) begin
					if (status.trl1_match && use_trailer_second) begin
						state_nxt = ST_TRL2;
					end else if (status.trl1_match) begin
						cmd.emit  = 1'b1;
						state_nxt = ST_DRAIN;
					end else begin
						state_nxt = ST_HUNT;
					end
				end
			end
			ST_TRL2: begin
				if (take) begin
					if (status.trl2_match) begin
						cmd.emit  = 1'b1;
						state_nxt = ST_DRAIN;
					end else begin
						state_nxt = ST_HUNT;
					end
				end
			end
			ST_DRAIN: begin
				if (!status.drain_busy) begin
					state_nxt = ST_HUNT;
				end
			end
			default: begin
				state_nxt = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- src/htfr_dp.sv -----
// ----------------------------------------------------------------------------
// htfr_dp: frame receiver datapath
// Byte compares, payload count, payload store and the read-out pipeline.
// ----------------------------------------------------------------------------
module htfr_dp #(
	parameter int MAX_PAYLOAD = htfr_pkg::MAX_PAYLOAD
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [htfr_pkg::BYTE_W-1:0]   rx_byte,
	input  htfr_pkg::cfg_t                cfg,
	input  htfr_pkg::ctrl_cmd_t           cmd,
	output htfr_pkg::dp_status_t          status,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [htfr_pkg::BYTE_W-1:0]   payload_byte,
	output logic [htfr_pkg::IDX_W-1:0]    byte_index,
	output logic                          last_byte
);

	localparam int CW   = $clog2(MAX_PAYLOAD + 1);
	localparam int AW   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CMPW = (CW > htfr_pkg::LEN_W) ? CW : htfr_pkg::LEN_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD);

	logic [CW-1:0] fill_count_q, fill_nxt, eff_len;
	logic          room;
	logic          ram_we;

	logic [CW-1:0] rd_idx_q;
	logic          drain_active_q;
	logic          issue, issue_last, out_load;
	logic          rd_vld_s1;
	logic [CW-1:0] rd_idx_s1;
	logic          rd_last_s1;
	logic [htfr_pkg::BYTE_W-1:0] rd_data;

	logic                        out_valid_q;
	logic [htfr_pkg::BYTE_W-1:0] out_byte_q;
	logic [htfr_pkg::IDX_W-1:0]  out_idx_q;
	logic                        out_last_q;

	// length 0 acts as 1, over-range clips to the store depth
	always_comb begin
		if (cfg.payload_length == '0) begin
			eff_len = CW'(1);
		end else if (CMPW'(cfg.payload_length) > CMPW'(MAX_CNT)) begin
			eff_len = MAX_CNT;
		end else begin
			eff_len = CW'(cfg.payload_length);
		end
	end

	assign room     = fill_count_q < MAX_CNT;
	assign fill_nxt = room ? fill_count_q + CW'(1) : fill_count_q;
	assign ram_we   = cmd.store && room;

	assign status.hdr1_match = (rx_byte == cfg.header_first);
	assign status.hdr2_match = (rx_byte == cfg.header_second);
	assign status.trl1_match = (rx_byte == cfg.trailer_first);
	assign status.trl2_match = (rx_byte == cfg.trailer_second);
	assign status.fill_done  = (fill_nxt >= eff_len);
	assign status.drain_busy = drain_active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
		end else if (cmd.clr_fill) begin
			fill_count_q <= '0;
		end else if (cmd.store) begin
			fill_count_q <= fill_nxt;
		end
	end

	// read-out: RAM read register is stage 1, output register is stage 2
	assign out_load   = rd_vld_s1 && (!out_valid_q || !out_stall);
	assign issue      = drain_active_q && (!rd_vld_s1 || out_load);
	assign issue_last = (rd_idx_q + CW'(1)) == fill_count_q;

	htfr_ram #(
		.WIDTH (htfr_pkg::BYTE_W),
		.DEPTH (MAX_PAYLOAD)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_count_q[AW-1:0]),
		.wdata (rx_byte),
		.re    (issue),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_active_q <= 1'b0;
			rd_idx_q       <= '0;
			rd_vld_s1      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.emit) begin
				drain_active_q <= 1'b1;
				rd_idx_q       <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
				if (issue_last) begin
					drain_active_q <= 1'b0;
				end
			end
			if (issue) begin
				rd_vld_s1 <= 1'b1;
			end else if (out_load) begin
				rd_vld_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1  <= rd_idx_q;
			rd_last_s1 <= issue_last;
		end
		if (out_load) begin
			out_byte_q <= rd_data;
			out_idx_q  <= htfr_pkg::IDX_W'(rd_idx_s1);
			out_last_q <= rd_last_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_byte_q;
	assign byte_index   = out_idx_q;
	assign last_byte    = out_last_q;

`ifndef ASSERT_OFF
	a_emit_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (drain_active_q && rd_idx_q == '0))
		else $error("drain not started after frame completion");
	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && drain_active_q))
		else $error("payload store written while draining");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (rd_idx_q < fill_count_q))
		else $error("payload read beyond stored bytes");
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= MAX_CNT)
		else $error("fill count beyond store depth");
`endif

endmodule

// ----- src/header_trailer_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// header_trailer_frame_receiver: fixed-length frame deframer
// Hunts header bytes, captures a fixed payload, checks trailer, emits payload.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall / rx_byte): one received byte per
//  transaction. A byte is taken every cycle while hunting headers, storing
//  payload or checking trailers. in_stall is high only in the drain state,
//  entered when a frame completes, left once its payload reads are issued.
//  Output channel (out_valid / out_stall / payload_byte, byte_index,
//  last_byte): one transaction per stored payload byte, in order, last_byte
//  set on the final one. Only complete frames (header, payload, trailer all
//  matched) produce output.
//  Read-out: once the final trailer byte is taken the drain starts and each
//  payload byte passes the RAM read register, then the output register; an
//  N-byte frame streams at one byte per cycle while out_stall is low, the
//  input held off while the payload store (one read port) is read out.
//  Output stall: the read pipeline (RAM read register + output register)
//  holds; no data is lost. Input resumes once all reads are issued, so new
//  bytes can be hunted while the tail of a frame still waits to be taken.
//  Reset: hunting the first header, registers at their defaults, store
//  contents undefined (only bytes written in the current frame are read).
//  Config: APB, register i at byte address 4*i; write only while idle.
// ----------------------------------------------------------------------------
module header_trailer_frame_receiver #(
	parameter int MAX_PAYLOAD = htfr_pkg::MAX_PAYLOAD
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// received byte channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [htfr_pkg::BYTE_W-1:0]   rx_byte,
	// payload channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [htfr_pkg::BYTE_W-1:0]   payload_byte,
	output logic [htfr_pkg::IDX_W-1:0]    byte_index,
	output logic                          last_byte,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [htfr_pkg::ADDR_W-1:0]   paddr,
	input  logic [htfr_pkg::DATA_W-1:0]   pwdata,
	output logic [htfr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	htfr_pkg::cfg_t       cfg_q;
	htfr_pkg::ctrl_cmd_t  cmd;
	htfr_pkg::dp_status_t status;
	logic                 cfg_wr;
	logic [htfr_pkg::REG_SEL_W-1:0] reg_sel;

	// ---------------- config registers ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[htfr_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.payload_length     <= htfr_pkg::RST_PAYLOAD_LENGTH;
			cfg_q.header_first       <= htfr_pkg::RST_HEADER_FIRST;
			cfg_q.header_second      <= htfr_pkg::RST_HEADER_SECOND;
			cfg_q.use_header_second  <= 1'b1;
			cfg_q.trailer_first      <= htfr_pkg::RST_TRAILER_FIRST;
			cfg_q.trailer_second     <= htfr_pkg::RST_TRAILER_SECOND;
			cfg_q.use_trailer_second <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				htfr_pkg::REG_PAYLOAD_LENGTH:
					cfg_q.payload_length <= pwdata[htfr_pkg::LEN_W-1:0];
				htfr_pkg::REG_HEADER_FIRST:
					cfg_q.header_first <= pwdata[htfr_pkg::BYTE_W-1:0];
				htfr_pkg::REG_HEADER_SECOND:
					cfg_q.header_second <= pwdata[htfr_pkg::BYTE_W-1:0];
				htfr_pkg::REG_USE_HEADER_SECOND:
					cfg_q.use_header_second <= pwdata[0];
				htfr_pkg::REG_TRAILER_FIRST:
					cfg_q.trailer_first <= pwdata[htfr_pkg::BYTE_W-1:0];
				htfr_pkg::REG_TRAILER_SECOND:
					cfg_q.trailer_second <= pwdata[htfr_pkg::BYTE_W-1:0];
				htfr_pkg::REG_USE_TRAILER_SECOND:
					cfg_q.use_trailer_second <= pwdata[0];
				default: begin
					// unmapped address: write ignored
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			htfr_pkg::REG_PAYLOAD_LENGTH:
				prdata = htfr_pkg::DATA_W'(cfg_q.payload_length);
			htfr_pkg::REG_HEADER_FIRST:
				prdata = htfr_pkg::DATA_W'(cfg_q.header_first);
			htfr_pkg::REG_HEADER_SECOND:
				prdata = htfr_pkg::DATA_W'(cfg_q.header_second);
			htfr_pkg::REG_USE_HEADER_SECOND:
				prdata = htfr_pkg::DATA_W'(cfg_q.use_header_second);
			htfr_pkg::REG_TRAILER_FIRST:
				prdata = htfr_pkg::DATA_W'(cfg_q.trailer_first);
			htfr_pkg::REG_TRAILER_SECOND:
				prdata = htfr_pkg::DATA_W'(cfg_q.trailer_second);
			htfr_pkg::REG_USE_TRAILER_SECOND:
				prdata = htfr_pkg::DATA_W'(cfg_q.use_trailer_second);
			default:
				prdata = '0;
		endcase
	end

	// ---------------- controller ----------------
	htfr_ctrl u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.use_header_second  (cfg_q.use_header_second),
		.use_trailer_second (cfg_q.use_trailer_second),
		.status             (status),
		.cmd                (cmd)
	);

	// ---------------- datapath ----------------
	htfr_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.last_byte    (last_byte)
	);

endmodule
